// ----- rtl/apjb_pkg.sv -----
`default_nettype none

package apjb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAMES_W   = 13;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FRAMES_W-1:0] CAPACITY_RESET = 13'd4096;
  localparam logic [FRAMES_W-1:0] PRIME_RESET    = 13'd0;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_RENDER  = 2'd1,
    FUNC_RESTART = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 2'd0,
    REG_PRIME    = 2'd1,
    REG_PAUSED   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    func_t                       func;
    logic signed [SAMPLE_W-1:0]  in_sample_0;
    logic signed [SAMPLE_W-1:0]  in_sample_1;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  out_sample_0;
    logic signed [SAMPLE_W-1:0]  out_sample_1;
    logic                        accepted;
    logic                        played;
    logic                        underran;
    logic                        playing;
    logic [FRAMES_W-1:0]         held_frames;
    logic [CNT_W-1:0]            dropped_total;
    logic [CNT_W-1:0]            underrun_total;
  } out_item_t;

  typedef struct packed {
    logic exec;
  } apjb_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/apjb_ctrl.sv -----
`default_nettype none

module apjb_ctrl
  import apjb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output apjb_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign busy      = (state_r == S_RESP);
  assign out_valid = (state_r == S_RESP);
  assign cmd.exec  = start && !busy;

  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = cmd.exec ? S_RESP : S_IDLE;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_resp_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without a preceding transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("transfer without result");

endmodule

`default_nettype wire

// ----- rtl/apjb_dp.sv -----
`default_nettype none

module apjb_dp
  import apjb_pkg::*;
#(
  parameter int MAX_DEPTH_FRAMES = 4096,
  parameter int NUM_CHANNELS     = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire apjb_cmd_t             cmd,
  input  wire in_item_t              in_item,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t                  out_item
);

  localparam int PTR_W  = (MAX_DEPTH_FRAMES > 1) ? $clog2(MAX_DEPTH_FRAMES) : 1;
  localparam int FILL_W = $clog2(MAX_DEPTH_FRAMES + 1);
  localparam int CMP_W  = (FILL_W > FRAMES_W) ? FILL_W : FRAMES_W;
  localparam int WORD_W = 2 * SAMPLE_W;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_DEPTH_FRAMES - 1);
  localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(MAX_DEPTH_FRAMES);

  logic [WORD_W-1:0] mem [MAX_DEPTH_FRAMES];

  logic [FRAMES_W-1:0] capacity_r, prime_r;
  logic                paused_r;

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              priming_r, priming_nxt;
  logic [CNT_W-1:0]  dropped_r, dropped_nxt;
  logic [CNT_W-1:0]  underrun_r, underrun_nxt;

  logic acc_r, acc_nxt;
  logic ply_r, ply_nxt;
  logic und_r, und_nxt;

  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] wr_word;
  logic              wr_en, rd_en;

  logic [CMP_W-1:0] cap_ext, eff_cap, prime_ext, eff_prime, fill_ext;

  always_comb begin
    cap_ext = CMP_W'(capacity_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > DEPTH_CMP) begin
      eff_cap = DEPTH_CMP;
    end else begin
      eff_cap = cap_ext;
    end
    prime_ext = CMP_W'(prime_r);
    eff_prime = (prime_ext < eff_cap) ? prime_ext : eff_cap;
    fill_ext  = CMP_W'(fill_r);
  end

  always_comb begin
    wr_word[SAMPLE_W-1:0] = in_item.in_sample_0;
    wr_word[WORD_W-1:SAMPLE_W] = (NUM_CHANNELS > 1) ? in_item.in_sample_1 : '0;
  end

  always_comb begin
    logic silent;
    silent       = 1'b0;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    priming_nxt  = priming_r;
    dropped_nxt  = dropped_r;
    underrun_nxt = underrun_r;
    acc_nxt      = 1'b0;
    ply_nxt      = 1'b0;
    und_nxt      = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    if (cmd.exec) begin
      unique case (in_item.func)
        FUNC_PUSH: begin
          if (fill_ext < eff_cap) begin
            wr_en      = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
            acc_nxt    = 1'b1;
          end else if (dropped_r != '1) begin
            dropped_nxt = dropped_r + 1'b1;
          end
        end
        FUNC_RENDER: begin
          if (paused_r) begin
            silent = 1'b1;
          end else if (priming_r) begin
            if (fill_ext < eff_prime) begin
              silent = 1'b1;
            end else begin
              priming_nxt = 1'b0;
            end
          end
          if (!silent) begin
            if (fill_r != '0) begin
              rd_en      = 1'b1;
              rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
              fill_nxt   = fill_r - 1'b1;
              ply_nxt    = 1'b1;
            end else begin
              und_nxt = 1'b1;
              if (underrun_r != '1) begin
                underrun_nxt = underrun_r + 1'b1;
              end
            end
          end
        end
        FUNC_RESTART: begin
          rd_ptr_nxt  = '0;
          wr_ptr_nxt  = '0;
          fill_nxt    = '0;
          priming_nxt = 1'b1;
        end
        FUNC_NOP: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_r     <= '0;
      priming_r  <= 1'b1;
      dropped_r  <= '0;
      underrun_r <= '0;
      acc_r      <= 1'b0;
      ply_r      <= 1'b0;
      und_r      <= 1'b0;
    end else begin
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_r     <= fill_nxt;
      priming_r  <= priming_nxt;
      dropped_r  <= dropped_nxt;
      underrun_r <= underrun_nxt;
      if (cmd.exec) begin
        acc_r <= acc_nxt;
        ply_r <= ply_nxt;
        und_r <= und_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      prime_r    <= PRIME_RESET;
      paused_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAPACITY: capacity_r <= cfg_data[FRAMES_W-1:0];
        REG_PRIME:    prime_r    <= cfg_data[FRAMES_W-1:0];
        REG_PAUSED:   paused_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_item.out_sample_0   = ply_r ? rd_data_r[SAMPLE_W-1:0] : '0;
    out_item.out_sample_1   = ply_r ? rd_data_r[WORD_W-1:SAMPLE_W] : '0;
    out_item.accepted       = acc_r;
    out_item.played         = ply_r;
    out_item.underran       = und_r;
    out_item.playing        = !priming_r;
    out_item.held_frames    = FRAMES_W'(fill_r);
    out_item.dropped_total  = dropped_r;
    out_item.underrun_total = underrun_r;
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= DEPTH_CMP)
    else $error("fill level beyond store depth");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({acc_r, ply_r, und_r}))
    else $error("more than one outcome flag set");

  a_play_only_when_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (ply_r || und_r) |-> !priming_r)
    else $error("frame played or underrun while priming");

endmodule

`default_nettype wire

// ----- rtl/audio_playback_jitter_buffer.sv -----
// Latency: result strobe in the cycle right after the start transfer.
// A start is taken only while not busy; busy covers the result cycle, so the
// block cannot take a new item until its last result has been shown.
// Reset (rst_n low, synchronous): empty FIFO, priming, counters cleared,
// registers at capacity 4096, prime 0, not paused. Frame store is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none

module audio_playback_jitter_buffer
  import apjb_pkg::*;
#(
  parameter int MAX_DEPTH_FRAMES = 4096,
  parameter int NUM_CHANNELS     = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  output out_item_t                  out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  apjb_cmd_t cmd;

  assign cfg_ready = 1'b1;

  apjb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  apjb_dp #(
    .MAX_DEPTH_FRAMES (MAX_DEPTH_FRAMES),
    .NUM_CHANNELS     (NUM_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
